FILE: rtl/fvg_pkg.sv
// Package for the fair value gap tracker: sizes, event codes and sequencer states.
// Used by rtl/fair_value_gap_tracker_unit.sv and rtl/fvg_checker.sv.
package fvg_pkg;
    localparam int MAX_GAPS   = 16;
    localparam int SLOT_W     = $clog2(MAX_GAPS);
    localparam int PRICE_W    = 32;
    localparam int COUNT_W    = $clog2(MAX_GAPS + 1);
    localparam int VISIT_W    = 16;
    localparam int KIND_W     = 3;
    localparam int S_DATA_W   = 160;
    localparam int M_DATA_W   = 192;

    typedef logic [PRICE_W-1:0] price_t;
    typedef logic [SLOT_W-1:0]  slot_t;

    typedef enum logic [KIND_W-1:0] {
        EV_SUMMARY   = 3'd0,
        EV_NEW       = 3'd1,
        EV_MERGED    = 3'd2,
        EV_MITIGATED = 3'd3,
        EV_EVICTED   = 3'd4
    } event_kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MERGE,
        ST_SCAN,
        ST_PICK,
        ST_AGE,
        ST_FIRST,
        ST_MIT,
        ST_EVICT
    } state_t;
endpackage

FILE: rtl/fair_value_gap_tracker_unit.sv
// Top level of the fair value gap tracker: detection, gap table and event sequencer.
// Depends on rtl/fvg_pkg.sv.
//
// Channel  Direction  Contents
// s_       in         tuser: command; tdata: open, high, low, close, stamp
// m_       out        tuser: event kind; tdata: gap fields and counts; tlast: summary
// cfg_     in         merge_adjacent in bit 0
//
// A bar runs through these steps in order: the accept, one merge check, a tracking
// pass over the table, a slot pick, a pass that offers the mitigations and then the
// summary. A new or merged gap adds a step before the mitigations that offers its
// event; an eviction on a full table adds an age scan over the table before that step
// and a step after the mitigations that offers the eviction. A clear offers the summary.
// Reset is synchronous and active low; it clears all valid bits and the bar counters.
// A stalled result holds the sequencer and its outputs.
module fair_value_gap_tracker_unit (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [fvg_pkg::S_DATA_W-1:0] s_tdata,  // open, high, low, close, stamp
    input  logic                       s_tuser,   // command
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // slot, bearish, top, bottom, middle, bar number, stamp, visits, bullish, bearish count
    output logic [fvg_pkg::M_DATA_W-1:0] m_tdata,
    output logic [fvg_pkg::KIND_W-1:0] m_tuser,   // event kind
    output logic                       m_tlast,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic                       cfg_data
);
    import fvg_pkg::*;

    state_t state_reg, state_next;
    slot_t  idx_reg, idx_next;
    logic   merge_reg;

    logic [31:0] bars_seen_reg;
    logic [1:0]  hist_reg;
    price_t older_high_reg, older_low_reg, prior_open_reg, prior_close_reg;
    logic [31:0] prior_stamp_reg;
    slot_t newest_slot_reg;
    logic  newest_valid_reg;

    logic [MAX_GAPS-1:0] slot_active_reg, slot_bearish_reg, mit_mask_reg, inside_reg;
    price_t      slot_top_reg    [MAX_GAPS];
    price_t      slot_bottom_reg [MAX_GAPS];
    logic [31:0] slot_barno_reg  [MAX_GAPS];
    logic [31:0] slot_stamp_reg  [MAX_GAPS];
    logic [VISIT_W-1:0] slot_visits_reg [MAX_GAPS];

    logic   cmd_reg, found_reg, bear_reg, merged_reg, place_reg, evict_reg;
    price_t hi_reg, lo_reg, open_reg, close_reg, top_reg, bot_reg;
    logic [31:0] stamp_reg, best_reg;
    slot_t  pick_reg;

    price_t in_open, in_high, in_low, in_close;
    logic [31:0] in_stamp, mid_num, age;
    logic   det_bull, det_bear, accept, merge_ok, any_free, inz, mit;
    slot_t  addr, first_free;
    logic [MAX_GAPS-1:0] act_p, bear_p;
    logic [COUNT_W-1:0] n_bull, n_bear;

    logic          o_valid, o_bear, o_last;
    slot_t         o_slot;
    price_t        o_top, o_bot, o_mid;
    logic [31:0]   o_barno, o_stamp;
    logic [VISIT_W-1:0] o_visits;
    event_kind_t   o_kind;
    logic [PRICE_W:0] mid_sum;

    logic sum_pending_reg;
    logic sum_take;
    logic to_sum;

    assign in_open  = s_tdata[31:0];
    assign in_high  = s_tdata[63:32];
    assign in_low   = s_tdata[95:64];
    assign in_close = s_tdata[127:96];
    assign in_stamp = s_tdata[159:128];

    assign s_tready  = (state_reg == ST_IDLE) && !sum_pending_reg;
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign mid_num   = bars_seen_reg - 32'd1;

    assign det_bull = hist_reg[1] && (older_high_reg < in_low) &&
                      (prior_close_reg > prior_open_reg);
    assign det_bear = hist_reg[1] && !det_bull && (older_low_reg > in_high) &&
                      (prior_close_reg < prior_open_reg);

    always_comb begin
        case (state_reg)
            ST_MERGE, ST_FIRST: addr = newest_slot_reg;
            ST_EVICT:           addr = pick_reg;
            default:            addr = idx_reg;
        endcase
    end

    assign merge_ok = found_reg && merge_reg && newest_valid_reg &&
                      slot_active_reg[newest_slot_reg] &&
                      (slot_bearish_reg[newest_slot_reg] == bear_reg) &&
                      (slot_barno_reg[newest_slot_reg] == mid_num - 32'd1);

    assign inz = (lo_reg <= slot_top_reg[addr]) && (hi_reg >= slot_bottom_reg[addr]);
    assign mit = slot_bearish_reg[addr] ? (close_reg > slot_top_reg[addr])
                                        : (close_reg < slot_bottom_reg[addr]);
    assign age = bars_seen_reg - slot_barno_reg[addr];

    always_comb begin
        first_free = '0;
        for (int i = MAX_GAPS - 1; i >= 0; i--) begin
            if (!slot_active_reg[i]) begin
                first_free = slot_t'(i);
            end
        end
    end
    assign any_free = ~&slot_active_reg;

    always_comb begin
        act_p  = slot_active_reg;
        bear_p = slot_bearish_reg;
        if (place_reg) begin
            act_p[pick_reg]  = 1'b1;
            bear_p[pick_reg] = bear_reg;
        end
    end
    assign n_bull = COUNT_W'($countones(act_p & ~bear_p));
    assign n_bear = COUNT_W'($countones(act_p & bear_p));

    always_comb begin
        o_valid  = 1'b0;
        o_last   = 1'b0;
        o_kind   = EV_SUMMARY;
        o_slot   = addr;
        o_bear   = slot_bearish_reg[addr];
        o_top    = slot_top_reg[addr];
        o_bot    = slot_bottom_reg[addr];
        o_barno  = slot_barno_reg[addr];
        o_stamp  = slot_stamp_reg[addr];
        o_visits = slot_visits_reg[addr];
        case (state_reg)
            ST_FIRST: begin
                o_valid = 1'b1;
                o_kind  = merged_reg ? EV_MERGED : EV_NEW;
                if (!merged_reg) begin
                    o_slot   = pick_reg;
                    o_bear   = bear_reg;
                    o_top    = top_reg;
                    o_bot    = bot_reg;
                    o_barno  = mid_num;
                    o_stamp  = prior_stamp_reg;
                    o_visits = '0;
                end
            end
            ST_MIT: begin
                o_valid = mit_mask_reg[idx_reg];
                o_kind  = EV_MITIGATED;
            end
            ST_EVICT: begin
                o_valid = 1'b1;
                o_kind  = EV_EVICTED;
            end
            ST_PICK, ST_IDLE, ST_MERGE, ST_SCAN, ST_AGE: begin
                o_valid = 1'b0;
            end
            default: begin
                o_valid = 1'b0;
            end
        endcase
    end

    assign sum_take = sum_pending_reg && m_tready;
    assign m_tvalid = o_valid || sum_pending_reg;

    assign mid_sum = {1'b0, o_top} + {1'b0, o_bot};
    assign o_mid   = mid_sum[PRICE_W:1];

    always_comb begin
        if (sum_pending_reg) begin
            m_tuser = EV_SUMMARY;
            m_tlast = 1'b1;
            m_tdata = {1'b0, n_bear, n_bull, 181'd0};
        end else begin
            m_tuser = o_kind;
            m_tlast = o_last;
            m_tdata = {1'b0, n_bear, n_bull, o_visits, o_stamp, o_barno,
                       o_mid, o_bot, o_top, o_bear, o_slot};
        end
    end

    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept && !s_tuser) begin
                    state_next = ST_MERGE;
                end
            end
            ST_MERGE: begin
                idx_next   = '0;
                state_next = ST_SCAN;
            end
            ST_SCAN: begin
                idx_next = idx_reg + slot_t'(1);
                if (idx_reg == slot_t'(MAX_GAPS - 1)) begin
                    state_next = ST_PICK;
                end
            end
            ST_PICK: begin
                idx_next = '0;
                if (found_reg && !merged_reg && !any_free) begin
                    state_next = ST_AGE;
                end else if (found_reg) begin
                    state_next = ST_FIRST;
                end else begin
                    state_next = ST_MIT;
                end
            end
            ST_AGE: begin
                idx_next = idx_reg + slot_t'(1);
                if (idx_reg == slot_t'(MAX_GAPS - 1)) begin
                    state_next = ST_FIRST;
                end
            end
            ST_FIRST: begin
                idx_next = '0;
                if (m_tready) begin
                    state_next = ST_MIT;
                end
            end
            ST_MIT: begin
                if (!mit_mask_reg[idx_reg] || m_tready) begin
                    idx_next = idx_reg + slot_t'(1);
                    if (idx_reg == slot_t'(MAX_GAPS - 1)) begin
                        state_next = evict_reg ? ST_EVICT : ST_IDLE;
                    end
                end
            end
            ST_EVICT: begin
                if (m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign to_sum = (state_reg == ST_MIT && state_next == ST_IDLE) ||
                    (state_reg == ST_EVICT && m_tready) ||
                    (accept && s_tuser);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            idx_reg          <= '0;
            merge_reg        <= 1'b0;
            bars_seen_reg    <= '0;
            hist_reg         <= '0;
            older_high_reg   <= '0;
            older_low_reg    <= '0;
            prior_open_reg   <= '0;
            prior_close_reg  <= '0;
            prior_stamp_reg  <= '0;
            newest_slot_reg  <= '0;
            newest_valid_reg <= 1'b0;
            slot_active_reg  <= '0;
            mit_mask_reg     <= '0;
            place_reg        <= 1'b0;
            evict_reg        <= 1'b0;
            merged_reg       <= 1'b0;
            found_reg        <= 1'b0;
            cmd_reg          <= 1'b0;
            sum_pending_reg  <= 1'b0;
        end else begin
            state_reg <= (sum_pending_reg && !sum_take) ? state_reg : state_next;
            idx_reg   <= idx_next;
            if (cfg_valid && cfg_ready) begin
                merge_reg <= cfg_data;
            end
            if (to_sum) begin
                sum_pending_reg <= 1'b1;
            end else if (sum_take) begin
                sum_pending_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        cmd_reg      <= s_tuser;
                        found_reg    <= det_bull || det_bear;
                        bear_reg     <= det_bear;
                        top_reg      <= det_bear ? older_low_reg : in_low;
                        bot_reg      <= det_bear ? in_high : older_high_reg;
                        hi_reg       <= in_high;
                        lo_reg       <= in_low;
                        open_reg     <= in_open;
                        close_reg    <= in_close;
                        stamp_reg    <= in_stamp;
                        mit_mask_reg <= '0;
                        merged_reg   <= 1'b0;
                        place_reg    <= 1'b0;
                        evict_reg    <= 1'b0;
                        if (s_tuser) begin
                            bars_seen_reg    <= '0;
                            hist_reg         <= '0;
                            older_high_reg   <= '0;
                            older_low_reg    <= '0;
                            prior_open_reg   <= '0;
                            prior_close_reg  <= '0;
                            prior_stamp_reg  <= '0;
                            newest_slot_reg  <= '0;
                            newest_valid_reg <= 1'b0;
                            slot_active_reg  <= '0;
                        end
                    end
                end
                ST_MERGE: begin
                    if (merge_ok) begin
                        merged_reg <= 1'b1;
                        if (slot_top_reg[addr] > top_reg) begin
                            slot_top_reg[addr] <= slot_top_reg[addr];
                        end else begin
                            slot_top_reg[addr] <= top_reg;
                        end
                        if (slot_bottom_reg[addr] < bot_reg) begin
                            slot_bottom_reg[addr] <= slot_bottom_reg[addr];
                        end else begin
                            slot_bottom_reg[addr] <= bot_reg;
                        end
                        slot_barno_reg[addr]  <= mid_num;
                        slot_stamp_reg[addr]  <= prior_stamp_reg;
                        slot_visits_reg[addr] <= '0;
                        inside_reg[addr]      <= 1'b0;
                    end
                end
                ST_SCAN: begin
                    if (slot_active_reg[addr] && !(merged_reg && addr == newest_slot_reg)) begin
                        if (inz && !inside_reg[addr] && !(&slot_visits_reg[addr])) begin
                            slot_visits_reg[addr] <= slot_visits_reg[addr] + VISIT_W'(1);
                        end
                        inside_reg[addr] <= inz;
                        if (mit) begin
                            slot_active_reg[addr] <= 1'b0;
                            mit_mask_reg[addr]    <= 1'b1;
                        end
                    end
                end
                ST_PICK: begin
                    if (found_reg && !merged_reg && any_free) begin
                        pick_reg  <= first_free;
                        place_reg <= 1'b1;
                    end
                end
                ST_AGE: begin
                    if (idx_reg == '0 || age > best_reg) begin
                        best_reg <= age;
                        pick_reg <= addr;
                    end
                    if (idx_reg == slot_t'(MAX_GAPS - 1)) begin
                        place_reg <= 1'b1;
                        evict_reg <= 1'b1;
                    end
                end
                default: begin
                end
            endcase
            if (sum_take && !cmd_reg) begin
                older_high_reg  <= hi_reg;
                older_low_reg   <= lo_reg;
                prior_open_reg  <= open_reg;
                prior_close_reg <= close_reg;
                prior_stamp_reg <= stamp_reg;
                bars_seen_reg   <= bars_seen_reg + 32'd1;
                if (!hist_reg[1]) begin
                    hist_reg <= hist_reg + 2'd1;
                end
                if (place_reg) begin
                    slot_active_reg[pick_reg]  <= 1'b1;
                    slot_bearish_reg[pick_reg] <= bear_reg;
                    slot_top_reg[pick_reg]     <= top_reg;
                    slot_bottom_reg[pick_reg]  <= bot_reg;
                    slot_barno_reg[pick_reg]   <= mid_num;
                    slot_stamp_reg[pick_reg]   <= prior_stamp_reg;
                    slot_visits_reg[pick_reg]  <= '0;
                    inside_reg[pick_reg]       <= 1'b0;
                    newest_slot_reg            <= pick_reg;
                    newest_valid_reg           <= 1'b1;
                    place_reg                  <= 1'b0;
                end
            end
        end
    end
endmodule

FILE: rtl/fvg_checker.sv
// Port-level checker for the fair value gap tracker, bound to the top level.
// Depends on rtl/fvg_pkg.sv and rtl/fair_value_gap_tracker_unit.sv.
module fvg_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_tvalid,
    input logic                         s_tready,
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [fvg_pkg::M_DATA_W-1:0] m_tdata,
    input logic [fvg_pkg::KIND_W-1:0]   m_tuser,
    input logic                         m_tlast
);
    import fvg_pkg::*;

    a_busy_out: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready)
        else $error("input taken while a result is offered");

    a_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("block ready straight after a transaction");

    a_summary_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |-> (m_tuser == EV_SUMMARY))
        else $error("closing summary carries an event kind");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=>
            (m_tvalid && $stable(m_tuser) && $stable(m_tdata) && $stable(m_tlast)))
        else $error("stalled result changed");
endmodule

bind fair_value_gap_tracker_unit fvg_checker u_fvg_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
